/* design/uss_pkg.sv */
// ----------------------------------------------------------------------------
// uss_pkg: shared definitions for the unordered key set
// Sizes, operation and status codes, sequencer states and interface structs.
// ----------------------------------------------------------------------------
package uss_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 7;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [KEY_BITS-1:0] wr_data;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [CNT_W-1:0] fill;
    } t_result;

endpackage

/* design/uss_ram.sv */
// ----------------------------------------------------------------------------
// uss_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module uss_ram #(
    parameter int DEPTH_P  = 64,
    parameter int WIDTH_P  = 32,
    parameter int ADDR_W_P = $clog2(DEPTH_P)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ADDR_W_P-1:0] i_wr_addr,
    input  logic [WIDTH_P-1:0]  i_wr_data,
    input  logic                i_rd_en,
    input  logic [ADDR_W_P-1:0] i_rd_addr,
    output logic [WIDTH_P-1:0]  o_rd_data
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* design/uss_seq.sv */
// ----------------------------------------------------------------------------
// uss_seq: request sequencer of the key set
// Holds the fill count, appends on add, scans the table one entry per cycle
// on delete and query, and moves the last entry into the hole on delete.
// ----------------------------------------------------------------------------
module uss_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic [1:0]                     i_kind,
    input  logic [uss_pkg::KEY_BITS-1:0]   i_key,
    input  logic [uss_pkg::CNT_W-1:0]      i_cap,
    output uss_pkg::t_mem_req              o_mem,
    input  logic [uss_pkg::KEY_BITS-1:0]   i_rd_data,
    output uss_pkg::t_result               o_res,
    input  logic                           i_res_ready
);

    localparam int AW = uss_pkg::ADDR_W;
    localparam int CW = uss_pkg::CNT_W;

    uss_pkg::t_state               r_state, n_state;
    logic                          r_is_query, n_is_query;
    logic [uss_pkg::KEY_BITS-1:0]  r_key, n_key;
    logic [AW-1:0]                 r_idx, n_idx;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [CW-1:0]                 r_count, n_count;
    logic [1:0]                    r_status, n_status;

    logic          accept;
    logic          hit;
    logic          at_last;
    logic [AW-1:0] last_idx;
    logic          full;

    assign accept   = i_req_valid && (r_state == uss_pkg::ST_IDLE);
    assign last_idx = AW'(r_count - CW'(1));
    assign hit      = (i_rd_data == r_key);
    assign at_last  = (r_idx == last_idx);
    assign full     = (r_count >= i_cap);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            uss_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((i_kind == uss_pkg::KIND_DEL || i_kind == uss_pkg::KIND_QUERY)
                        && (r_count != '0)) begin
                        n_state = uss_pkg::ST_SCAN;
                    end else begin
                        n_state = uss_pkg::ST_DONE;
                    end
                end
            end
            uss_pkg::ST_SCAN: begin
                if (hit && !r_is_query && !at_last) begin
                    n_state = uss_pkg::ST_MOVE;
                end else if (hit || at_last) begin
                    n_state = uss_pkg::ST_DONE;
                end
            end
            uss_pkg::ST_MOVE: begin
                n_state = uss_pkg::ST_DONE;
            end
            uss_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = uss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = uss_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory requests. The table is never read and written in
    // the same cycle, so no forwarding is needed.
    always_comb begin
        n_is_query = r_is_query;
        n_key      = r_key;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_count    = r_count;
        n_status   = r_status;
        o_mem      = '0;
        case (r_state)
            uss_pkg::ST_IDLE: begin
                if (accept) begin
                    n_is_query = (i_kind == uss_pkg::KIND_QUERY);
                    n_key      = i_key;
                    n_idx      = '0;
                    n_status   = uss_pkg::STAT_OK;
                    case (i_kind)
                        uss_pkg::KIND_ADD: begin
                            if (full) begin
                                n_status = uss_pkg::STAT_FULL;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = AW'(r_count);
                                o_mem.wr_data = i_key;
                                n_count       = r_count + CW'(1);
                            end
                        end
                        uss_pkg::KIND_DEL, uss_pkg::KIND_QUERY: begin
                            if (r_count == '0) begin
                                if (i_kind == uss_pkg::KIND_QUERY) begin
                                    n_status = uss_pkg::STAT_ABSENT;
                                end
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = '0;
                            end
                        end
                        default: begin
                            n_status = uss_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            uss_pkg::ST_SCAN: begin
                if (hit) begin
                    if (!r_is_query) begin
                        if (at_last) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            // Fetch the last entry to fill the hole.
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = last_idx;
                            n_pos         = r_idx;
                        end
                    end
                end else if (at_last) begin
                    if (r_is_query) begin
                        n_status = uss_pkg::STAT_ABSENT;
                    end
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx + AW'(1);
                    n_idx         = r_idx + AW'(1);
                end
            end
            uss_pkg::ST_MOVE: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_pos;
                o_mem.wr_data = i_rd_data;
                n_count       = r_count - CW'(1);
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uss_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_query <= n_is_query;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_status   <= n_status;
    end

    assign o_req_ready  = (r_state == uss_pkg::ST_IDLE);
    assign o_res.valid  = (r_state == uss_pkg::ST_DONE);
    assign o_res.status = r_status;
    assign o_res.fill   = r_count;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1)) || (r_count + CW'(1) == $past(r_count)))
        else $error("fill count moved by more than one");

    a_grow_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count) + CW'(1)) |->
            $past(accept && (i_kind == uss_pkg::KIND_ADD)))
        else $error("fill count grew without an accepted add");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (r_state == uss_pkg::ST_IDLE || r_state == uss_pkg::ST_MOVE))
        else $error("table written outside add or move");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uss_pkg::ST_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("scan index beyond stored entries");

endmodule

/* design/unordered_set_swap_remove.sv */
// ----------------------------------------------------------------------------
// unordered_set_swap_remove: bounded unordered key set with swap-remove
// Keys live in a 64-entry RAM packed below a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries kind and key: add,
//   delete or query. One request is worked on at a time.
//   Result channel (o_out_valid / i_out_stall) returns one result per
//   request: status and the fill count after the operation.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the capacity;
//   it is always ready and must be written only while the block is idle.
// Sequencing:
//   An add goes from accept straight to its result. A delete or query reads
//   the table one entry per cycle through the RAM read port, so it scans
//   at most the N stored keys. A delete that finds its key before the
//   last entry takes an extra step that moves the last entry into the hole.
// Reset clears the fill count, sets the capacity to 64 and empties the
// output register; the table contents are not cleared.
// A stalled result sits in the output register while the next request is
// accepted and worked on; that request completes once the register frees.
// ----------------------------------------------------------------------------
module unordered_set_swap_remove (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic [31:0]                         i_key,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [uss_pkg::CNT_W-1:0]           o_fill_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uss_pkg::CAP_W-1:0]           i_cfg_data
);

    logic [uss_pkg::CAP_W-1:0]    r_capacity;
    logic [uss_pkg::CNT_W-1:0]    eff_cap;
    logic                         req_ready;
    uss_pkg::t_mem_req            mem_req;
    logic [uss_pkg::KEY_BITS-1:0] rd_data;
    uss_pkg::t_result             res;
    logic                         res_ready;

    logic                         r_out_valid;
    logic [1:0]                   r_status;
    logic [uss_pkg::CNT_W-1:0]    r_fill;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= uss_pkg::CAP_W'(uss_pkg::DEPTH);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Capacity above the built depth is clipped to the depth.
    assign eff_cap = (r_capacity > uss_pkg::CAP_W'(uss_pkg::DEPTH))
                   ? uss_pkg::CNT_W'(uss_pkg::DEPTH)
                   : uss_pkg::CNT_W'(r_capacity);

    uss_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (req_ready),
        .i_kind      (i_kind),
        .i_key       (i_key[uss_pkg::KEY_BITS-1:0]),
        .i_cap       (eff_cap),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    uss_ram #(
        .DEPTH_P (uss_pkg::DEPTH),
        .WIDTH_P (uss_pkg::KEY_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = !req_ready;

    // Output register takes a new result whenever it is empty or draining.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_status <= res.status;
            r_fill   <= res.fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for unordered_set_swap_remove
// Drives add, delete and query requests under random idle and stall
// patterns, and runs them through several capacity settings. A behavioral
// copy of the key set predicts each result. Directed requests come first,
// then random traffic that fills the table, drains it and hits the edge cases.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The kind code that the block treats as no operation.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_PHASES    = 7;
    localparam int PHASE_REQUESTS   = 118;
    localparam int DRAIN_CYCLES     = 70;

    typedef struct packed {
        logic [1:0]                status;
        logic [uss_pkg::CNT_W-1:0] fill;
    } t_set_result;

    typedef struct packed {
        logic                      is_cfg;
        logic [uss_pkg::CAP_W-1:0] cap;
        logic [1:0]                kind;
        logic [31:0]               key;
        logic                      has_typed;
        logic [1:0]                status;
        logic [uss_pkg::CNT_W-1:0] fill;
    } t_step;

    localparam int N_DIRECTED = 27;
    localparam t_step DIRECTED [0:N_DIRECTED-1] = '{
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, uss_pkg::STAT_ABSENT, 7'd0},
        '{1'b0, 7'd0, uss_pkg::KIND_DEL,   32'h0000_0005, 1'b1, uss_pkg::STAT_OK,     7'd0},
        '{1'b0, 7'd0, KIND_UNUSED,         32'hFFFF_FFFF, 1'b1, uss_pkg::STAT_OK,     7'd0},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h0000_0000, 1'b1, uss_pkg::STAT_OK,     7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'hFFFF_FFFF, 1'b1, uss_pkg::STAT_OK,     7'd2},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h0000_0000, 1'b1, uss_pkg::STAT_OK,     7'd3},
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, uss_pkg::STAT_OK,     7'd3},
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'h1234_5678, 1'b1, uss_pkg::STAT_ABSENT, 7'd3},
        '{1'b0, 7'd0, uss_pkg::KIND_DEL,   32'h0000_0000, 1'b1, uss_pkg::STAT_OK,     7'd2},
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, uss_pkg::STAT_OK,     7'd2},
        '{1'b0, 7'd0, uss_pkg::KIND_DEL,   32'h0000_0000, 1'b1, uss_pkg::STAT_OK,     7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, uss_pkg::STAT_ABSENT, 7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h8000_0000, 1'b1, uss_pkg::STAT_OK,     7'd2},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h7FFF_FFFF, 1'b1, uss_pkg::STAT_OK,     7'd3},
        '{1'b0, 7'd0, uss_pkg::KIND_DEL,   32'hFFFF_FFFF, 1'b1, uss_pkg::STAT_OK,     7'd2},
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'h7FFF_FFFF, 1'b0, uss_pkg::STAT_OK,     7'd0},
        '{1'b1, 7'd0, uss_pkg::KIND_ADD,   32'h0000_0000, 1'b0, uss_pkg::STAT_OK,     7'd0},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h0000_0001, 1'b1, uss_pkg::STAT_FULL,   7'd2},
        '{1'b0, 7'd0, uss_pkg::KIND_DEL,   32'h8000_0000, 1'b1, uss_pkg::STAT_OK,     7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h0000_0002, 1'b1, uss_pkg::STAT_FULL,   7'd1},
        '{1'b1, 7'd1, uss_pkg::KIND_ADD,   32'h0000_0000, 1'b0, uss_pkg::STAT_OK,     7'd0},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h0000_0003, 1'b1, uss_pkg::STAT_FULL,   7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_DEL,   32'h7FFF_FFFF, 1'b1, uss_pkg::STAT_OK,     7'd0},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'hAAAA_AAAA, 1'b1, uss_pkg::STAT_OK,     7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_ADD,   32'h5555_5555, 1'b1, uss_pkg::STAT_FULL,   7'd1},
        '{1'b0, 7'd0, KIND_UNUSED,         32'h0000_0000, 1'b1, uss_pkg::STAT_OK,     7'd1},
        '{1'b0, 7'd0, uss_pkg::KIND_QUERY, 32'h5555_5555, 1'b1, uss_pkg::STAT_ABSENT, 7'd1}
    };

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic [1:0]                i_kind      = uss_pkg::KIND_ADD;
    logic [31:0]               i_key       = '0;
    logic                      i_out_stall = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [uss_pkg::CAP_W-1:0] i_cfg_data  = '0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [1:0]                o_status;
    logic [uss_pkg::CNT_W-1:0] o_fill_count;
    logic                      o_cfg_ready;

    // Behavioral copy of the key set.
    logic [31:0]               model_slots [uss_pkg::DEPTH];
    int                        model_count = 0;
    logic [uss_pkg::CAP_W-1:0] model_cap   = 7'd64;

    t_set_result pending_results[$];
    t_set_result oldest;
    bit          steady      = 1'b0;
    int          errors      = 0;
    int          checked     = 0;
    int          requests    = 0;
    int          refusals    = 0;
    int          cap_writes  = 0;
    int          peak_fill   = 0;

    unordered_set_swap_remove dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_fill_count (o_fill_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    // Applies one request to the key set and returns the result it gives.
    function automatic t_set_result apply_request(logic [1:0] kind, logic [31:0] key);
        t_set_result r;
        int          limit;
        int          pos;
        r.status = uss_pkg::STAT_OK;
        limit = (model_cap > uss_pkg::DEPTH) ? uss_pkg::DEPTH : model_cap;
        pos = model_count;
        for (int i = model_count - 1; i >= 0; i--) begin
            if (model_slots[i] == key) pos = i;
        end
        case (kind)
            uss_pkg::KIND_ADD: begin
                if (model_count >= limit) begin
                    r.status = uss_pkg::STAT_FULL;
                    refusals++;
                end else begin
                    model_slots[model_count] = key;
                    model_count++;
                end
            end
            uss_pkg::KIND_DEL: begin
                // Swap-remove: the last entry fills the hole.
                if (pos < model_count) begin
                    model_slots[pos] = model_slots[model_count - 1];
                    model_count--;
                end
            end
            uss_pkg::KIND_QUERY: begin
                if (pos >= model_count) r.status = uss_pkg::STAT_ABSENT;
            end
            default: ;
        endcase
        if (model_count > peak_fill) peak_fill = model_count;
        r.fill = model_count[uss_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic issue_request(input logic [1:0] kind, input logic [31:0] key,
                                 input bit has_typed, input t_set_result typed);
        int          gap;
        t_set_result predicted;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_request(kind, key);
        pending_results.push_back(has_typed ? typed : predicted);
        requests++;
    endtask

    // The capacity is only written once every outstanding result is back.
    task automatic write_capacity(input logic [uss_pkg::CAP_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_cap = value;
        cap_writes++;
    endtask

    // Mostly keys already stored or from a small pool, so deletes and
    // queries hit; the rest are full-width random keys.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && model_count > 0) return model_slots[$urandom_range(0, model_count - 1)];
        if (sel < 8) return $urandom_range(0, 15);
        return $urandom();
    endfunction

    initial begin
        int                        roll;
        int                        add_pct;
        logic [1:0]                kind;
        logic [uss_pkg::CAP_W-1:0] cap;
        t_set_result               typed;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].is_cfg) begin
                write_capacity(DIRECTED[i].cap);
            end else begin
                typed.status = DIRECTED[i].status;
                typed.fill   = DIRECTED[i].fill;
                issue_request(DIRECTED[i].kind, DIRECTED[i].key, DIRECTED[i].has_typed, typed);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin cap = 7'd127; add_pct = 80; end
                1: begin cap = 7'd5; add_pct = 30; end
                2: begin cap = uss_pkg::CAP_W'($urandom_range(1, 64)); add_pct = 50; end
                3: begin cap = 7'd64; add_pct = 75; end
                4: begin cap = 7'd0; add_pct = 40; end
                5: begin cap = 7'd1; add_pct = 50; end
                default: begin
                    cap = uss_pkg::CAP_W'($urandom_range(65, 127));
                    add_pct = 45;
                end
            endcase
            write_capacity(cap);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll == 0) kind = KIND_UNUSED;
                else if (roll <= add_pct) kind = uss_pkg::KIND_ADD;
                else if (roll[0]) kind = uss_pkg::KIND_DEL;
                else kind = uss_pkg::KIND_QUERY;
                issue_request(kind, pick_key(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d requests, %0d results checked, %0d capacity writes",
                 requests, checked, cap_writes);
        $display("tb: %0d adds refused as full, peak fill %0d of %0d",
                 refusals, peak_fill, uss_pkg::DEPTH);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: a random stall before each result.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d fill %0d",
                         $time, o_status, o_fill_count);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                checked++;
                if (o_status !== oldest.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest.status, o_status);
                    errors++;
                end
                if (o_fill_count !== oldest.fill) begin
                    $display("%0t: fill count expected %0d, got %0d",
                             $time, oldest.fill, o_fill_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
